### rtl/core/qefd_pkg.sv
// qualified earliest-free dispatcher: shared constants and types
`timescale 1ns / 1ps

package qefd_pkg;

    localparam int NUM_WORKERS  = 4;
    localparam int LEVEL_REGS   = 4;
    localparam int LEVEL_W      = 4;
    localparam int DURATION_W   = 16;
    localparam int TIME_W       = 32;
    localparam int WORKER_IDX_W = 2;
    localparam int ACTIVE_W     = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEVEL0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ACTIVE = 3'd4;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;
    localparam logic [ACTIVE_W-1:0] ACTIVE_MAX   = ACTIVE_W'(NUM_WORKERS);
    localparam logic [WORKER_IDX_W-1:0] LAST_WORKER = WORKER_IDX_W'(NUM_WORKERS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

endpackage

### rtl/core/qefd_if.sv
// job, result and configuration channels of the dispatcher
`timescale 1ns / 1ps

interface qefd_job_if;
    logic                             valid;
    logic                             ready;
    logic [qefd_pkg::LEVEL_W-1:0]     job_level;
    logic [qefd_pkg::DURATION_W-1:0]  job_duration;

    modport source (output valid, output job_level, output job_duration, input ready);
    modport sink   (input valid, input job_level, input job_duration, output ready);
endinterface

interface qefd_res_if;
    logic                               valid;
    logic                               ready;
    logic                               assigned;
    logic [qefd_pkg::WORKER_IDX_W-1:0]  worker_index;
    logic [qefd_pkg::TIME_W-1:0]        start_time;
    logic [qefd_pkg::TIME_W-1:0]        end_time;

    modport source (output valid, output assigned, output worker_index,
                    output start_time, output end_time, input ready);
    modport sink   (input valid, input assigned, input worker_index,
                    input start_time, input end_time, output ready);
endinterface

interface qefd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [qefd_pkg::CFG_IDX_W-1:0]   index;
    logic [qefd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/qualified_earliest_free_dispatcher.sv
// qualified earliest-free dispatcher top level
`timescale 1ns / 1ps

// Picks, for each job word, the active worker whose skill level meets the job's
// level and whose free time is earliest (lowest index on a tie), starts the job at
// that free time and moves the worker's free time to start plus duration, saturating
// at all ones. When no worker qualifies the result word has assigned = 0 and all
// other fields zero, and no free time changes. Between one acceptance and the next, the
// block takes the word, then walks the workers in order through the single shared
// level/time comparator, then does the saturating add and the write-back of the chosen
// free time. The result sits in an output register, so a new job is taken while the
// previous result waits; the write-back holds only if that register is still full.
// Configuration writes are taken every cycle and must only come while the block is idle.
module qualified_earliest_free_dispatcher (
    input  logic          clk,
    input  logic          rst_n,
    qefd_job_if.sink      job,
    qefd_res_if.source    result,
    qefd_cfg_if.sink      cfg
);

    qefd_pkg::state_t state_reg, state_next;

    logic [qefd_pkg::LEVEL_W-1:0]  level_reg [qefd_pkg::LEVEL_REGS];
    logic [qefd_pkg::ACTIVE_W-1:0] active_reg;
    logic [qefd_pkg::TIME_W-1:0]   free_time_reg [qefd_pkg::NUM_WORKERS];

    logic [qefd_pkg::LEVEL_W-1:0]      need_reg;
    logic [qefd_pkg::DURATION_W-1:0]   dur_reg;
    logic [qefd_pkg::WORKER_IDX_W-1:0] scan_idx_reg;
    logic                              found_reg;
    logic [qefd_pkg::WORKER_IDX_W-1:0] best_reg;
    logic [qefd_pkg::TIME_W-1:0]       best_time_reg;

    logic                              res_valid_reg;
    logic                              res_assigned_reg;
    logic [qefd_pkg::WORKER_IDX_W-1:0] res_index_reg;
    logic [qefd_pkg::TIME_W-1:0]       res_start_reg;
    logic [qefd_pkg::TIME_W-1:0]       res_end_reg;

    logic                          job_take;
    logic                          scan_en;
    logic                          write_en;
    logic                          write_stall;
    logic [qefd_pkg::ACTIVE_W-1:0] count_eff;
    logic                          qualifies;
    logic                          take;
    logic [qefd_pkg::TIME_W-1:0]   cur_time;
    logic [qefd_pkg::TIME_W:0]     sum;
    logic [qefd_pkg::TIME_W-1:0]   end_time;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < qefd_pkg::LEVEL_REGS; i++)
            begin
                level_reg[i] <= '0;
            end
            active_reg <= qefd_pkg::ACTIVE_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index < qefd_pkg::CFG_IDX_ACTIVE)
            begin
                level_reg[cfg.index[qefd_pkg::WORKER_IDX_W-1:0]] <=
                    cfg.data[qefd_pkg::LEVEL_W-1:0];
            end
            else if (cfg.index == qefd_pkg::CFG_IDX_ACTIVE)
            begin
                active_reg <= cfg.data[qefd_pkg::ACTIVE_W-1:0];
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qefd_pkg::ST_IDLE:
            begin
                if (job.valid)
                begin
                    state_next = qefd_pkg::ST_SCAN;
                end
            end
            qefd_pkg::ST_SCAN:
            begin
                if (scan_idx_reg == qefd_pkg::LAST_WORKER)
                begin
                    state_next = qefd_pkg::ST_WRITE;
                end
            end
            qefd_pkg::ST_WRITE:
            begin
                if (!write_stall)
                begin
                    state_next = qefd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = qefd_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        job.ready = 1'b0;
        scan_en   = 1'b0;
        write_en  = 1'b0;
        unique case (state_reg)
            qefd_pkg::ST_IDLE:  job.ready = 1'b1;
            qefd_pkg::ST_SCAN:  scan_en   = 1'b1;
            qefd_pkg::ST_WRITE: write_en  = !write_stall;
            default:            job.ready = 1'b0;
        endcase
    end

    assign job_take    = job.valid && job.ready;
    assign write_stall = res_valid_reg && !result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qefd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // shared compare unit: one worker per cycle
    assign count_eff = (active_reg > qefd_pkg::ACTIVE_MAX) ? qefd_pkg::ACTIVE_MAX : active_reg;
    assign cur_time  = free_time_reg[scan_idx_reg];
    assign qualifies = (level_reg[scan_idx_reg] >= need_reg) &&
                       ({1'b0, scan_idx_reg} < count_eff);
    assign take      = qualifies && (!found_reg || (cur_time < best_time_reg));

    // saturating end time
    assign sum      = {1'b0, best_time_reg} + {{(qefd_pkg::TIME_W + 1 - qefd_pkg::DURATION_W){1'b0}}, dur_reg};
    assign end_time = sum[qefd_pkg::TIME_W] ? {qefd_pkg::TIME_W{1'b1}} : sum[qefd_pkg::TIME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (job_take)
        begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (scan_en)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (take)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            need_reg <= job.job_level;
            dur_reg  <= job.job_duration;
        end
        if (scan_en && take)
        begin
            best_reg      <= scan_idx_reg;
            best_time_reg <= cur_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < qefd_pkg::NUM_WORKERS; i++)
            begin
                free_time_reg[i] <= '0;
            end
        end
        else if (write_en && found_reg)
        begin
            free_time_reg[best_reg] <= end_time;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (write_en)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            res_assigned_reg <= found_reg;
            res_index_reg    <= found_reg ? best_reg : '0;
            res_start_reg    <= found_reg ? best_time_reg : '0;
            res_end_reg      <= found_reg ? end_time : '0;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.assigned     = res_assigned_reg;
    assign result.worker_index = res_index_reg;
    assign result.start_time   = res_start_reg;
    assign result.end_time     = res_end_reg;

    // checks
    a_take_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> (state_reg == qefd_pkg::ST_SCAN) && (scan_idx_reg == '0))
        else $error("accepted job did not start the scan");

    a_unassigned_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.assigned) |->
            (result.worker_index == '0) && (result.start_time == '0) && (result.end_time == '0))
        else $error("unassigned result carries nonzero fields");

    a_end_not_before_start: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.assigned) |-> (result.end_time >= result.start_time))
        else $error("end time before start time");

    a_best_is_active: assert property (@(posedge clk) disable iff (!rst_n)
        (write_en && found_reg) |-> ({1'b0, best_reg} < count_eff))
        else $error("chosen worker is not active");

    a_free_time_written: assert property (@(posedge clk) disable iff (!rst_n)
        (write_en && found_reg) |=> (free_time_reg[$past(best_reg)] == result.end_time))
        else $error("free time does not match reported end time");

endmodule
